// File: hw/rtl/ilme_pkg.sv
// ---------------------------------------------------------------------------
// ilme_pkg
// Shared types and constants for the indexed list move-to-end block.
// ---------------------------------------------------------------------------
package ilme_pkg;

	localparam int MAX_ENTRIES = 1024;
	localparam int ID_W        = 11;                    // entry id and count width
	localparam int ADDR_W      = $clog2(MAX_ENTRIES);   // link memory address
	localparam int TDATA_W     = ((ID_W + 7) / 8) * 8;
	localparam int KIND_W      = 2;

	typedef enum logic [KIND_W-1:0] {
		KIND_BACK  = 2'd0,
		KIND_FRONT = 2'd1,
		KIND_LEFT  = 2'd2,
		KIND_RIGHT = 2'd3
	} kind_t;

	typedef logic [ID_W-1:0]   id_t;
	typedef logic [ADDR_W-1:0] addr_t;

	// clamp the written count into 1..MAX_ENTRIES
	function automatic id_t eff_count(input id_t c);
		id_t r;
		r = c;
		if (c == '0) begin
			r = id_t'(1);
		end else if (c > id_t'(MAX_ENTRIES)) begin
			r = id_t'(MAX_ENTRIES);
		end
		return r;
	endfunction

endpackage

// File: hw/rtl/indexed_list_move_to_end.sv
// ---------------------------------------------------------------------------
// indexed_list_move_to_end
// Doubly linked list over entry ids 1..N with move-to-back, move-to-front and
// neighbor queries. Left and right links live in two single-port memories.
//
// Input beat: s_tuser carries the kind (0 move to back, 1 move to front,
// 2 query left, 3 query right), s_tdata the entry id. Moves give no output;
// each query gives one output beat on m_tdata with the neighbor, 0 for none.
// Sequence: a query passes the link read and the response state; m_tvalid
// and s_tready both rise as it leaves the response state, which waits while
// an earlier output beat is stalled. An invalid id skips the link read.
// No new beat is taken before the last one is done. A move does one link
// read, then three write steps, since one link memory takes up to three
// writes through its single port. Moves that change nothing and moves with
// invalid ids keep s_tready high. Reset and every write of cfg_wdata rebuild
// the list by a sweep over all 1024 link entries with s_tready low.
// The output beat sits in its own register: when the receiver stalls a query
// result waits there, moves still run, and the next query waits only for it.
// ---------------------------------------------------------------------------
module indexed_list_move_to_end (
	input  logic                        clk,
	input  logic                        arst_n,
	// configuration: entry_count
	input  logic                        cfg_we,
	input  logic [ilme_pkg::ID_W-1:0]   cfg_wdata,
	// input beats
	input  logic                        s_tvalid,
	output logic                        s_tready,
	input  logic [ilme_pkg::TDATA_W-1:0] s_tdata,   // [10:0] item_id
	input  logic [ilme_pkg::KIND_W-1:0] s_tuser,    // [1:0] kind
	// output beats
	output logic                        m_tvalid,
	input  logic                        m_tready,
	output logic [ilme_pkg::TDATA_W-1:0] m_tdata    // [10:0] neighbor_id
);
	import ilme_pkg::*;

	typedef enum logic [6:0] {
		ST_IDLE = 7'b0000001,
		ST_CLR  = 7'b0000010,
		ST_RD   = 7'b0000100,
		ST_W1   = 7'b0001000,
		ST_W2   = 7'b0010000,
		ST_W3   = 7'b0100000,
		ST_RESP = 7'b1000000
	} state_t;

	state_t state_q;
	id_t    cnt_q;
	id_t    head_q;
	id_t    tail_q;
	addr_t  clr_q;
	kind_t  kind_q;
	id_t    item_q;
	logic   vld_q;
	logic   out_vld_q;
	id_t    out_data_q;

	// link memories and their registered read data
	id_t    l_mem [MAX_ENTRIES];
	id_t    r_mem [MAX_ENTRIES];
	id_t    rd_l_q;
	id_t    rd_r_q;
	logic   l_we, r_we, mem_re;
	addr_t  l_addr, r_addr;
	id_t    l_wdata, r_wdata;

	id_t    n_eff;
	id_t    in_id;
	kind_t  in_kind;
	logic   in_valid;
	logic   in_noop;
	logic   accept;
	logic   out_free;
	logic   is_back;
	id_t    clr_id;

	assign n_eff    = eff_count(cnt_q);
	assign in_id    = s_tdata[ID_W-1:0];
	assign in_kind  = kind_t'(s_tuser);
	assign in_valid = (in_id != '0) && (in_id <= n_eff);
	assign in_noop  = (in_kind == KIND_BACK)  ? (in_id == tail_q) :
	                  (in_kind == KIND_FRONT) ? (in_id == head_q) : 1'b0;
	assign s_tready = (state_q == ST_IDLE);
	assign accept   = s_tvalid && s_tready;
	assign out_free = !out_vld_q || m_tready;
	assign is_back  = (kind_q == KIND_BACK);
	assign clr_id   = id_t'(clr_q) + id_t'(1);

	assign m_tvalid = out_vld_q;
	assign m_tdata  = TDATA_W'(out_data_q);

	// memory port control
	always_comb begin
		l_we    = 1'b0;
		r_we    = 1'b0;
		mem_re  = 1'b0;
		l_addr  = '0;
		r_addr  = '0;
		l_wdata = '0;
		r_wdata = '0;
		unique case (state_q)
			ST_CLR: begin
				l_we    = 1'b1;
				r_we    = 1'b1;
				l_addr  = clr_q;
				r_addr  = clr_q;
				l_wdata = id_t'(clr_q);
				r_wdata = (clr_id < n_eff) ? clr_id + id_t'(1) : '0;
			end
			ST_RD: begin
				mem_re = 1'b1;
				l_addr = addr_t'(item_q - id_t'(1));
				r_addr = addr_t'(item_q - id_t'(1));
			end
			ST_W1: begin
				// the moved entry's own links
				l_we    = 1'b1;
				r_we    = 1'b1;
				l_addr  = addr_t'(item_q - id_t'(1));
				r_addr  = addr_t'(item_q - id_t'(1));
				l_wdata = is_back ? tail_q : '0;
				r_wdata = is_back ? '0 : head_q;
			end
			ST_W2: begin
				l_we = 1'b1;
				r_we = 1'b1;
				if (is_back) begin
					r_addr  = addr_t'(tail_q - id_t'(1));
					r_wdata = item_q;
					l_addr  = addr_t'(rd_r_q - id_t'(1));
					l_wdata = rd_l_q;
				end else begin
					l_addr  = addr_t'(head_q - id_t'(1));
					l_wdata = item_q;
					r_addr  = addr_t'(rd_l_q - id_t'(1));
					r_wdata = rd_r_q;
				end
			end
			ST_W3: begin
				// close the gap on the side that may be open
				if (is_back) begin
					r_we    = (rd_l_q != '0);
					r_addr  = addr_t'(rd_l_q - id_t'(1));
					r_wdata = rd_r_q;
				end else begin
					l_we    = (rd_r_q != '0);
					l_addr  = addr_t'(rd_r_q - id_t'(1));
					l_wdata = rd_l_q;
				end
			end
			ST_IDLE, ST_RESP: begin
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (l_we) begin
			l_mem[l_addr] <= l_wdata;
		end else if (mem_re) begin
			rd_l_q <= l_mem[l_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (r_we) begin
			r_mem[r_addr] <= r_wdata;
		end else if (mem_re) begin
			rd_r_q <= r_mem[r_addr];
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_CLR;
			cnt_q     <= id_t'(MAX_ENTRIES);
			head_q    <= id_t'(1);
			tail_q    <= id_t'(MAX_ENTRIES);
			clr_q     <= '0;
			vld_q     <= 1'b0;
			out_vld_q <= 1'b0;
		end else begin
			if (!cfg_we && state_q == ST_RESP && out_free) begin
				out_vld_q <= 1'b1;
			end else if (out_vld_q && m_tready) begin
				out_vld_q <= 1'b0;
			end
			if (cfg_we) begin
				cnt_q   <= cfg_wdata;
				head_q  <= id_t'(1);
				tail_q  <= eff_count(cfg_wdata);
				clr_q   <= '0;
				state_q <= ST_CLR;
			end else begin
				unique case (state_q)
					ST_CLR: begin
						clr_q <= clr_q + addr_t'(1);
						if (clr_q == '1) begin
							state_q <= ST_IDLE;
						end
					end
					ST_IDLE: begin
						if (accept) begin
							vld_q <= in_valid;
							if (in_kind == KIND_LEFT || in_kind == KIND_RIGHT) begin
								state_q <= in_valid ? ST_RD : ST_RESP;
							end else if (in_valid && !in_noop) begin
								state_q <= ST_RD;
							end
						end
					end
					ST_RD: begin
						state_q <= (kind_q == KIND_LEFT || kind_q == KIND_RIGHT) ?
						           ST_RESP : ST_W1;
					end
					ST_W1: begin
						state_q <= ST_W2;
					end
					ST_W2: begin
						state_q <= ST_W3;
					end
					ST_W3: begin
						if (is_back) begin
							if (item_q == head_q) begin
								head_q <= rd_r_q;
							end
							tail_q <= item_q;
						end else begin
							if (item_q == tail_q) begin
								tail_q <= rd_l_q;
							end
							head_q <= item_q;
						end
						state_q <= ST_IDLE;
					end
					ST_RESP: begin
						if (out_free) begin
							state_q <= ST_IDLE;
						end
					end
					default: begin
						state_q <= ST_IDLE;
					end
				endcase
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (accept) begin
			kind_q <= in_kind;
			item_q <= in_id;
		end
		if (state_q == ST_RESP && out_free) begin
			if (!vld_q) begin
				out_data_q <= '0;
			end else begin
				out_data_q <= (kind_q == KIND_LEFT) ? rd_l_q : rd_r_q;
			end
		end
	end

endmodule

// File: hw/rtl/ilme_checker.sv
// ---------------------------------------------------------------------------
// ilme_checker
// Port-level checks for the indexed list move-to-end block.
// ---------------------------------------------------------------------------
module ilme_checker (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         cfg_we,
	input logic                         s_tvalid,
	input logic                         s_tready,
	input logic [ilme_pkg::KIND_W-1:0]  s_tuser,
	input logic                         m_tvalid,
	input logic                         m_tready,
	input logic [ilme_pkg::TDATA_W-1:0] m_tdata
);
	import ilme_pkg::*;

	// a stalled output beat stays up
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid)
		else $error("output beat dropped while stalled");

	// one query at a time: busy the cycle after an accepted query beat
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && !cfg_we &&
		(kind_t'(s_tuser) == KIND_LEFT || kind_t'(s_tuser) == KIND_RIGHT)
		|=> !s_tready)
		else $error("input accepted back to back");

	// a count write starts the rebuild sweep
	a_rebuild_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_we |=> !s_tready)
		else $error("input ready during rebuild");

	// neighbor ids stay within the id range
	a_out_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata <= TDATA_W'(MAX_ENTRIES)))
		else $error("neighbor id out of range");

endmodule

bind indexed_list_move_to_end ilme_checker u_ilme_checker (.*);

// File: dv/tb_indexed_list_move_to_end.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_indexed_list_move_to_end
// Drives move and neighbor-query beats into the linked-list block, keeps its
// own copy of the list to predict every query answer, and checks each output
// beat in order. Runs directed corner cases, random phases over several list
// sizes, a no-idle stretch and a long output stall.
// ---------------------------------------------------------------------------
module tb_indexed_list_move_to_end;
	import ilme_pkg::*;

	localparam int SETTLE_CYCLES = 12;     // covers a move still in flight
	localparam int HOLD_LEN      = 160;
	localparam int DRAIN_CYCLES  = 20;

	logic                clk;
	logic                arst_n;
	logic                cfg_we;
	id_t                 cfg_wdata;
	logic                s_tvalid;
	logic                s_tready;
	logic [TDATA_W-1:0]  s_tdata;   // [10:0] item_id
	logic [KIND_W-1:0]   s_tuser;   // [1:0] kind
	logic                m_tvalid;
	logic                m_tready;
	logic [TDATA_W-1:0]  m_tdata;   // [10:0] neighbor_id

	// predicted list
	id_t left_of  [0:MAX_ENTRIES];
	id_t right_of [0:MAX_ENTRIES];
	id_t head_id;
	id_t tail_id;
	id_t count_reg;

	id_t neighbor_q[$];
	id_t expected_nb;
	int  errors;
	bit  calm;
	int  hold_req;
	int  hold_left;

	indexed_list_move_to_end dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#3_000_000;
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

	function automatic int list_size();
		int n;
		n = int'(count_reg);
		if (n < 1) begin
			n = 1;
		end else if (n > MAX_ENTRIES) begin
			n = MAX_ENTRIES;
		end
		return n;
	endfunction

	function automatic void rebuild_order();
		int n;
		n = list_size();
		for (int i = 0; i <= MAX_ENTRIES; i++) begin
			left_of[i]  = '0;
			right_of[i] = '0;
		end
		for (int i = 1; i <= n; i++) begin
			left_of[i]  = id_t'(i - 1);
			right_of[i] = (i < n) ? id_t'(i + 1) : '0;
		end
		head_id = id_t'(1);
		tail_id = id_t'(n);
	endfunction

	function automatic void unlink(id_t a);
		id_t l;
		id_t r;
		l = left_of[a];
		r = right_of[a];
		if (l != '0) right_of[l] = r;
		if (r != '0) left_of[r] = l;
	endfunction

	function automatic void splice_to_back(id_t a);
		if (a == tail_id) return;
		if (a == head_id) head_id = right_of[a];
		unlink(a);
		left_of[a]        = tail_id;
		right_of[a]       = '0;
		right_of[tail_id] = a;
		tail_id           = a;
	endfunction

	function automatic void splice_to_front(id_t a);
		if (a == head_id) return;
		if (a == tail_id) tail_id = left_of[a];
		unlink(a);
		right_of[a]      = head_id;
		left_of[a]       = '0;
		left_of[head_id] = a;
		head_id          = a;
	endfunction

	// returns 1 when the op yields a neighbor beat
	function automatic bit predict_op(kind_t k, id_t a, output id_t nb);
		bit valid;
		bit answers;
		valid   = (a >= id_t'(1)) && (int'(a) <= list_size());
		answers = 1'b0;
		nb      = '0;
		case (k)
			KIND_BACK: begin
				if (valid) splice_to_back(a);
			end
			KIND_FRONT: begin
				if (valid) splice_to_front(a);
			end
			KIND_LEFT: begin
				answers = 1'b1;
				if (valid) nb = left_of[a];
			end
			default: begin
				answers = 1'b1;
				if (valid) nb = right_of[a];
			end
		endcase
		return answers;
	endfunction

	task automatic send_op(input kind_t k, input id_t a);
		int  gap;
		id_t nb;
		gap = 0;
		if (!calm && $urandom_range(99) < 18) gap = $urandom_range(4, 1);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= TDATA_W'(a);
		s_tuser  <= k;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		if (predict_op(k, a, nb)) neighbor_q.push_back(nb);
	endtask

	// mostly valid ids, with list ends favored and some out-of-range ids
	task automatic send_random_op();
		int    n;
		int    p;
		kind_t k;
		id_t   a;
		n = list_size();
		p = $urandom_range(99);
		if (p < 30) k = KIND_BACK;
		else if (p < 55) k = KIND_FRONT;
		else if (p < 78) k = KIND_LEFT;
		else k = KIND_RIGHT;
		p = $urandom_range(99);
		if (p < 3) a = '0;
		else if (p < 8) a = id_t'($urandom_range(2047, n + 1));
		else if (p < 14) a = head_id;
		else if (p < 20) a = tail_id;
		else a = id_t'($urandom_range(n, 1));
		send_op(k, a);
	endtask

	task automatic settle();
		s_tvalid <= 1'b0;
		while (neighbor_q.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_count(input id_t v);
		settle();
		cfg_we    <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we    <= 1'b0;
		count_reg = v;
		rebuild_order();
	endtask

	task automatic test_reset_order();
		send_op(KIND_LEFT, id_t'(1));
		send_op(KIND_RIGHT, id_t'(1));
		send_op(KIND_LEFT, id_t'(1024));
		send_op(KIND_RIGHT, id_t'(1024));
		send_op(KIND_RIGHT, id_t'(0));
		send_op(KIND_LEFT, id_t'(2047));
	endtask

	task automatic test_directed_moves();
		write_count(id_t'(5));
		send_op(KIND_BACK, id_t'(5));     // tail to back does nothing
		send_op(KIND_FRONT, id_t'(1));    // head to front does nothing
		send_op(KIND_BACK, id_t'(1));
		send_op(KIND_FRONT, id_t'(5));
		send_op(KIND_BACK, id_t'(3));
		send_op(KIND_BACK, id_t'(0));
		send_op(KIND_FRONT, id_t'(6));
		send_op(KIND_LEFT, id_t'(1));
		send_op(KIND_RIGHT, id_t'(5));
		send_op(KIND_RIGHT, id_t'(3));
		send_op(KIND_LEFT, id_t'(6));
	endtask

	task automatic test_count_extremes();
		write_count(id_t'(0));            // behaves as a one-entry list
		send_op(KIND_FRONT, id_t'(1));
		send_op(KIND_LEFT, id_t'(1));
		send_op(KIND_RIGHT, id_t'(2));
		write_count(id_t'(2047));         // clamps to the full list
		send_op(KIND_BACK, id_t'(1));
		send_op(KIND_LEFT, id_t'(1024));
		send_op(KIND_RIGHT, id_t'(1025));
	endtask

	task automatic test_random_small();
		int sizes[6];
		sizes = '{2, 3, 4, 7, 8, 16};
		foreach (sizes[i]) begin
			write_count(id_t'(sizes[i]));
			repeat (45) send_random_op();
		end
	endtask

	task automatic test_steady_stream();
		write_count(id_t'(1024));
		calm = 1'b1;
		repeat (60) send_random_op();
		settle();
		calm = 1'b0;
	endtask

	task automatic test_backpressure();
		write_count(id_t'(6));
		hold_req = HOLD_LEN;
		repeat (40) send_random_op();
	endtask

	task automatic test_random_counts();
		write_count(id_t'(1));
		repeat (20) send_random_op();
		write_count(id_t'($urandom_range(40, 9)));
		repeat (20) send_random_op();
		write_count(id_t'($urandom_range(1500, 41)));
		repeat (20) send_random_op();
	endtask

	// output side: random stalls, always ready while calm, or a counted hold-off when one is requested
	initial begin
		m_tready  <= 1'b0;
		hold_left = 0;
		forever begin
			@(posedge clk);
			if (hold_req > 0) begin
				hold_left = hold_req;
				hold_req  = 0;
			end
			if (hold_left > 0) begin
				m_tready <= 1'b0;
				hold_left--;
			end else if (calm) begin
				m_tready <= 1'b1;
			end else begin
				m_tready <= ($urandom_range(99) >= 18);
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			if (neighbor_q.size() == 0) begin
				$display("%0t: unexpected neighbor beat, expected none, actual %0d",
					$time, m_tdata);
				errors++;
			end else begin
				expected_nb = neighbor_q.pop_front();
				if (m_tdata !== TDATA_W'(expected_nb)) begin
					$display("%0t: neighbor_id expected %0d actual %0d",
						$time, expected_nb, m_tdata);
					errors++;
				end
			end
		end
	end

	initial begin
		errors    = 0;
		calm      = 1'b0;
		hold_req  = 0;
		count_reg = id_t'(1024);
		rebuild_order();
		arst_n    <= 1'b0;
		cfg_we    <= 1'b0;
		cfg_wdata <= '0;
		s_tvalid  <= 1'b0;
		s_tdata   <= '0;
		s_tuser   <= KIND_BACK;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		test_reset_order();
		test_directed_moves();
		test_count_extremes();
		test_random_small();
		test_steady_stream();
		test_backpressure();
		test_random_counts();

		s_tvalid <= 1'b0;
		while (neighbor_q.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (errors == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

endmodule

// File: sim.f
hw/rtl/ilme_pkg.sv
hw/rtl/indexed_list_move_to_end.sv
hw/rtl/ilme_checker.sv
dv/tb_indexed_list_move_to_end.sv
